// File: hdl/hlts_pkg.sv
package hlts_pkg;

  // Field widths
  localparam int REQ_TYPE_W   = 3;
  localparam int LOCK_ID_W    = 64;
  localparam int REPLY_TYPE_W = 3;
  localparam int VERSION_W    = 64;

  // Request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 3'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_ACQUIRE = 3'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_ABORT   = 3'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_COMMIT  = 3'd3;

  // Reply codes
  localparam logic [REPLY_TYPE_W-1:0] RT_GRANT_READ  = 3'd0;
  localparam logic [REPLY_TYPE_W-1:0] RT_GRANT_LOCK  = 3'd1;
  localparam logic [REPLY_TYPE_W-1:0] RT_REJECT_LOCK = 3'd2;
  localparam logic [REPLY_TYPE_W-1:0] RT_ABORT_ACK   = 3'd3;
  localparam logic [REPLY_TYPE_W-1:0] RT_COMMIT_ACK  = 3'd4;
  localparam logic [REPLY_TYPE_W-1:0] RT_NONE        = 3'd5;

  // Hash constants
  localparam logic [63:0] HASH_SEED = 64'h0000_0000_dead_beef;
  localparam logic [63:0] HASH_MULT = 64'h8803_55f2_1e6d_1965;
  localparam logic [63:0] MIX_MULT  = 64'h2127_599b_f432_5c37;
  // Starting state for an 8-byte key: seed ^ (8 * HASH_MULT), wrapped
  localparam logic [63:0] HASH_INIT = HASH_SEED ^ (HASH_MULT << 3);

  // One table entry
  typedef struct packed {
    logic                 held;
    logic [VERSION_W-1:0] ver;
  } entry_t;

endpackage

// File: hdl/hlts_req_if.sv
interface hlts_req_if;
  logic                             valid;
  logic                             ready;
  logic [hlts_pkg::REQ_TYPE_W-1:0]  req_type;
  logic [hlts_pkg::LOCK_ID_W-1:0]   lock_id;

  modport source (output valid, req_type, lock_id, input ready);
  modport sink (input valid, req_type, lock_id, output ready);
endinterface

// File: hdl/hlts_rsp_if.sv
interface hlts_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               send_reply;
  logic [hlts_pkg::REPLY_TYPE_W-1:0]  reply_type;
  logic [hlts_pkg::VERSION_W-1:0]     version;

  modport source (output valid, send_reply, reply_type, version, input ready);
  modport sink (input valid, send_reply, reply_type, version, output ready);
endinterface

// File: hdl/hashed_lock_table_server.sv
// Lock table server. The req channel carries one word per lock-manager
// message (req_type, lock_id); the rsp channel returns one word per message
// (send_reply, reply_type, version). Both use valid/ready; a word moves on a
// clock edge with valid and ready high.
// The lock id is hashed with a 64-bit fast-hash, reduced modulo TABLE_ENTRIES
// and used to read-modify-write one table entry (held bit, version).
// Sequence from the accepting edge until the reply word is valid: hashing on
// one shared 32x32 multiplier (three 64-bit products, three partial products
// each), then the remainder (four 16-bit digits, each a reciprocal multiply,
// a back-multiply and a subtract with one correction, all on the same
// multiplier), then one table read and one write-back. req.ready is high
// only while the sequencer is idle, so a new word is not accepted until
// the last one has finished write-back.
// Reset: rst clears the sequencer and the output register, then a clearing
// pass writes every entry to zero with req.ready low.
// Stall: the reply waits in an output register; the next message is
// accepted and processed meanwhile, and holds before write-back until the
// waiting reply has been taken.
module hashed_lock_table_server #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  hlts_req_if.sink   req,
  hlts_rsp_if.source rsp
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [31:0]   REM_N     = 32'(TABLE_ENTRIES);
  localparam logic [31:0]   MOD_RECIP = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);

  // Sequencer codes
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRE   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_POST  = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_READ  = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;

  logic [3:0]                            state;
  logic [IW-1:0]                         clr_idx;
  logic [hlts_pkg::REQ_TYPE_W-1:0]       kind;
  logic [63:0]                           work;
  logic [63:0]                           sum;
  logic [63:0]                           pr;
  logic [1:0]                            mstep;
  logic [1:0]                            rnd;
  logic [1:0]                            dcnt;
  logic [IW-1:0]                         rem;

  logic                                  out_valid;
  logic                                  out_send;
  logic [hlts_pkg::REPLY_TYPE_W-1:0]     out_type;
  logic [hlts_pkg::VERSION_W-1:0]        out_ver;

  hlts_pkg::entry_t                      mem [TABLE_ENTRIES];
  hlts_pkg::entry_t                      mem_rdata;
  hlts_pkg::entry_t                      mem_wdata;
  logic [IW-1:0]                         mem_waddr;
  logic                                  mem_we;

  logic [63:0]                           mul_k;
  logic [31:0]                           mul_a;
  logic [31:0]                           mul_b;
  logic [63:0]                           mul_p;
  logic [63:0]                           mix_out;
  logic [31:0]                           mod_x;
  logic [31:0]                           mod_t;
  logic [IW-1:0]                         rem_next;

  hlts_pkg::entry_t                      upd;
  logic                                  upd_we;
  logic                                  upd_send;
  logic [hlts_pkg::REPLY_TYPE_W-1:0]     upd_type;
  logic [hlts_pkg::VERSION_W-1:0]        upd_ver;
  logic                                  out_free;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.send_reply = out_send;
  assign rsp.reply_type = out_type;
  assign rsp.version    = out_ver;

  assign out_free = !out_valid || rsp.ready;

  // Shared multiplier: hash partial products, or during the remainder the
  // quotient estimate and its product with the table size
  assign mul_k = (rnd == 2'd1) ? hlts_pkg::HASH_MULT : hlts_pkg::MIX_MULT;
  always_comb begin
    if (state == S_MOD) begin
      if (mstep == 2'd0) begin
        mul_a = mod_x;
        mul_b = MOD_RECIP;
      end else begin
        mul_a = pr[63:32];
        mul_b = REM_N;
      end
    end else begin
      case (mstep)
        2'd0: begin
          mul_a = work[31:0];
          mul_b = mul_k[31:0];
        end
        2'd1: begin
          mul_a = work[31:0];
          mul_b = mul_k[63:32];
        end
        default: begin
          mul_a = work[63:32];
          mul_b = mul_k[31:0];
        end
      endcase
    end
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Tail of the mix step
  assign mix_out = sum ^ (sum >> 47);

  // One remainder digit: partial remainder with the next 16 hash bits,
  // minus the estimated multiple, corrected once
  assign mod_x    = 32'({rem, work[63:48]});
  assign mod_t    = mod_x - pr[31:0];
  assign rem_next = (mod_t >= REM_N) ? IW'(mod_t - REM_N) : mod_t[IW-1:0];

  // Decide the entry update and the reply from the entry read
  always_comb begin
    upd      = mem_rdata;
    upd_we   = 1'b0;
    upd_send = 1'b1;
    upd_type = hlts_pkg::RT_NONE;
    upd_ver  = '0;
    case (kind)
      hlts_pkg::REQ_READ: begin
        upd_type = hlts_pkg::RT_GRANT_READ;
        upd_ver  = mem_rdata.ver;
      end
      hlts_pkg::REQ_ACQUIRE: begin
        if (mem_rdata.held) begin
          upd_type = hlts_pkg::RT_REJECT_LOCK;
        end else begin
          upd.held = 1'b1;
          upd_we   = 1'b1;
          upd_type = hlts_pkg::RT_GRANT_LOCK;
        end
      end
      hlts_pkg::REQ_ABORT: begin
        upd.held = 1'b0;
        upd_we   = 1'b1;
        upd_type = hlts_pkg::RT_ABORT_ACK;
      end
      hlts_pkg::REQ_COMMIT: begin
        upd.held = 1'b0;
        upd.ver  = mem_rdata.ver + 64'd1;
        upd_we   = 1'b1;
        upd_type = hlts_pkg::RT_COMMIT_ACK;
      end
      default: begin
        upd_send = 1'b0;
      end
    endcase
  end

  // Table write port: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rem;
    mem_wdata = upd;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx;
      mem_wdata = '0;
    end else if (state == S_WRITE && out_free) begin
      mem_we = upd_we;
    end
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[rem];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      mstep   <= '0;
      rnd     <= '0;
      dcnt    <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            kind  <= req.req_type;
            work  <= req.lock_id;
            rnd   <= 2'd0;
            state <= S_PRE;
          end
        end
        S_PRE: begin
          work  <= work ^ (work >> 23);
          mstep <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          // product of step s lands in pr, folded into sum on step s+1
          pr    <= mul_p;
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: ;
            2'd1: sum <= pr;
            default: sum <= sum + {pr[31:0], 32'h0};
          endcase
          if (mstep == 2'd3) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          case (rnd)
            2'd0: begin
              work  <= hlts_pkg::HASH_INIT ^ mix_out;
              rnd   <= 2'd1;
              mstep <= 2'd0;
              state <= S_MUL;
            end
            2'd1: begin
              work  <= sum;
              rnd   <= 2'd2;
              state <= S_PRE;
            end
            default: begin
              work  <= mix_out;
              rem   <= '0;
              dcnt  <= '0;
              mstep <= 2'd0;
              state <= S_MOD;
            end
          endcase
        end
        S_MOD: begin
          // estimate, back-multiply, then subtract and advance a digit
          case (mstep)
            2'd0: begin
              pr    <= mul_p;
              mstep <= 2'd1;
            end
            2'd1: begin
              pr    <= mul_p;
              mstep <= 2'd2;
            end
            default: begin
              rem   <= rem_next;
              work  <= work << 16;
              mstep <= 2'd0;
              dcnt  <= dcnt + 2'd1;
              if (dcnt == 2'd3) begin
                state <= S_READ;
              end
            end
          endcase
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load on write-back, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE && out_free) begin
      out_send <= upd_send;
      out_type <= upd_type;
      out_ver  <= upd_ver;
    end
  end

  // A reply word appears only out of write-back
  a_reply_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_WRITE)
    else $error("reply loaded outside write-back");

  // The remainder always selects an entry inside the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> rem <= LAST_IDX)
    else $error("table index out of range");

  // Unrecognized messages never touch the table
  a_no_write_unknown: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && mem_we) |->
      (kind == hlts_pkg::REQ_ACQUIRE || kind == hlts_pkg::REQ_ABORT ||
       kind == hlts_pkg::REQ_COMMIT))
    else $error("table written for a message without an update");

  // An accepted word starts the hash
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == S_PRE)
    else $error("accepted word did not start hashing");

endmodule

// File: tb/tb_hashed_lock_table_server.sv
module tb_hashed_lock_table_server;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_ENTRIES  = 1024;
  localparam int RAND_REQS    = 1430;
  localparam int POOL_SIZE    = 24;
  localparam int IDLE_PCT     = 23;
  localparam int CALM_FIRST   = 500;
  localparam int CALM_LAST    = 800;
  localparam int SETTLE_CYC   = 120;

  typedef logic [hlts_pkg::REQ_TYPE_W-1:0]   kind_t;
  typedef logic [hlts_pkg::LOCK_ID_W-1:0]    id_t;
  typedef logic [hlts_pkg::REPLY_TYPE_W-1:0] rtype_t;
  typedef logic [hlts_pkg::VERSION_W-1:0]    ver_t;

  // codes 4..7 carry no lock-manager meaning
  localparam kind_t REQ_FIRST_UNKNOWN = 3'd4;

  typedef struct {
    kind_t kind;
    id_t   id;
    bit    drain_first;
  } lock_req_t;

  typedef struct {
    logic   send;
    rtype_t rtype;
    ver_t   ver;
  } lock_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hlts_req_if req_ch ();
  hlts_rsp_if rsp_ch ();

  hashed_lock_table_server #(
    .TABLE_ENTRIES(TBL_ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the lock table
  bit   held_shadow [TBL_ENTRIES];
  ver_t ver_shadow  [TBL_ENTRIES];

  lock_req_t   pending_reqs[$];
  lock_reply_t replies_due[$];
  id_t         id_pool [POOL_SIZE];

  int n_accepted = 0;
  int n_replies  = 0;
  int n_errors   = 0;
  int n_grants   = 0;
  int n_rejects  = 0;
  int n_passed   = 0;
  int n_reads    = 0;
  bit calm;

  assign calm = (n_accepted >= CALM_FIRST) && (n_accepted < CALM_LAST);

  // Fast-hash mixing round
  function automatic logic [63:0] scramble(input logic [63:0] h);
    logic [63:0] t;
    t = h ^ (h >> 23);
    t = t * hlts_pkg::MIX_MULT;
    t = t ^ (t >> 47);
    return t;
  endfunction

  function automatic int unsigned slot_of(input id_t id);
    logic [63:0] h;
    h = hlts_pkg::HASH_INIT ^ scramble(id);
    h = h * hlts_pkg::HASH_MULT;
    h = scramble(h);
    return int'(h % TBL_ENTRIES);
  endfunction

  function automatic id_t rand_id();
    return {$urandom, $urandom};
  endfunction

  // Find another id that lands on the same entry
  function automatic id_t slot_partner(input id_t id);
    id_t cand;
    do begin
      cand = rand_id();
    end while (cand == id || slot_of(cand) != slot_of(id));
    return cand;
  endfunction

  // Apply one accepted request to the shadow table and queue its reply
  task automatic apply_lock_req(input kind_t kind, input id_t id);
    int unsigned s;
    lock_reply_t r;
    s = slot_of(id);
    r.send  = 1'b1;
    r.rtype = hlts_pkg::RT_NONE;
    r.ver   = '0;
    case (kind)
      hlts_pkg::REQ_READ: begin
        r.rtype = hlts_pkg::RT_GRANT_READ;
        r.ver   = ver_shadow[s];
      end
      hlts_pkg::REQ_ACQUIRE: begin
        if (!held_shadow[s]) begin
          held_shadow[s] = 1'b1;
          r.rtype = hlts_pkg::RT_GRANT_LOCK;
        end else begin
          r.rtype = hlts_pkg::RT_REJECT_LOCK;
        end
      end
      hlts_pkg::REQ_ABORT: begin
        held_shadow[s] = 1'b0;
        r.rtype = hlts_pkg::RT_ABORT_ACK;
      end
      hlts_pkg::REQ_COMMIT: begin
        ver_shadow[s]  = ver_shadow[s] + 1'b1;
        held_shadow[s] = 1'b0;
        r.rtype = hlts_pkg::RT_COMMIT_ACK;
      end
      default: begin
        r.send  = 1'b0;
        r.rtype = hlts_pkg::RT_NONE;
      end
    endcase
    replies_due.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic add_req(input kind_t kind, input id_t id, input bit drain);
    lock_req_t q;
    q.kind        = kind;
    q.id          = id;
    q.drain_first = drain;
    pending_reqs.push_back(q);
  endtask

  // Request driver
  always @(posedge clk) begin : req_drive
    lock_req_t nxt;
    bit fire;
    bit hold_off;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire) begin
        apply_lock_req(req_ch.req_type, req_ch.lock_id);
        n_accepted++;
      end
      // hold the word until it is taken
      if (!(req_ch.valid && !fire)) begin
        hold_off = 1'b0;
        if (pending_reqs.size() == 0)
          hold_off = 1'b1;
        else if (pending_reqs[0].drain_first && replies_due.size() != 0)
          hold_off = 1'b1;
        else if (!calm && $urandom_range(0, 99) < IDLE_PCT)
          hold_off = 1'b1;
        if (hold_off) begin
          req_ch.valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= nxt.kind;
          req_ch.lock_id  <= nxt.id;
        end
      end
    end
  end

  // Reply monitor and backpressure
  always @(posedge clk) begin : rsp_check
    lock_reply_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_replies++;
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected reply word type=%0d", rsp_ch.reply_type));
        end else begin
          want = replies_due.pop_front();
          if (rsp_ch.send_reply !== want.send)
            report_mismatch($sformatf("send_reply got %b want %b",
                                      rsp_ch.send_reply, want.send));
          if (rsp_ch.reply_type !== want.rtype)
            report_mismatch($sformatf("reply_type got %0d want %0d",
                                      rsp_ch.reply_type, want.rtype));
          if (rsp_ch.version !== want.ver)
            report_mismatch($sformatf("version got %h want %h",
                                      rsp_ch.version, want.ver));
          case (want.rtype)
            hlts_pkg::RT_GRANT_LOCK:  n_grants++;
            hlts_pkg::RT_REJECT_LOCK: n_rejects++;
            hlts_pkg::RT_GRANT_READ:  n_reads++;
            hlts_pkg::RT_NONE:        n_passed++;
            default: ;
          endcase
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Stimulus and end of run
  initial begin : stim
    id_t id_lo, id_hi, id_c, id_d;
    id_t id_pick;
    kind_t kind;
    int pick;
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      held_shadow[i] = 1'b0;
      ver_shadow[i]  = '0;
    end

    id_lo = '0;
    id_hi = '1;
    id_c  = rand_id();
    id_d  = slot_partner(id_c);

    // directed: every operation, free and held entries, collisions
    add_req(hlts_pkg::REQ_READ,    id_lo, 1'b0);
    add_req(hlts_pkg::REQ_ACQUIRE, id_lo, 1'b0);
    add_req(hlts_pkg::REQ_ACQUIRE, id_lo, 1'b0);
    add_req(hlts_pkg::REQ_ABORT,   id_lo, 1'b0);
    add_req(hlts_pkg::REQ_ABORT,   id_lo, 1'b0);
    add_req(hlts_pkg::REQ_ACQUIRE, id_hi, 1'b0);
    add_req(hlts_pkg::REQ_COMMIT,  id_hi, 1'b0);
    add_req(hlts_pkg::REQ_READ,    id_hi, 1'b0);
    add_req(hlts_pkg::REQ_ACQUIRE, id_hi, 1'b0);
    add_req(hlts_pkg::REQ_ACQUIRE, id_c,  1'b1);
    add_req(hlts_pkg::REQ_ACQUIRE, id_d,  1'b0);
    add_req(hlts_pkg::REQ_COMMIT,  id_d,  1'b0);
    add_req(hlts_pkg::REQ_READ,    id_c,  1'b0);
    for (int k = 0; k < 4; k++)
      add_req(kind_t'(REQ_FIRST_UNKNOWN + k), (k % 2) ? id_hi : id_c, 1'b0);
    add_req(hlts_pkg::REQ_READ,    id_hi, 1'b0);
    add_req(hlts_pkg::REQ_COMMIT,  id_lo, 1'b0);
    add_req(hlts_pkg::REQ_COMMIT,  id_lo, 1'b0);
    add_req(hlts_pkg::REQ_READ,    id_lo, 1'b0);
    add_req(hlts_pkg::REQ_ABORT,   id_hi, 1'b0);
    add_req(hlts_pkg::REQ_ACQUIRE, id_hi, 1'b0);

    // small id pool with shared entries so locks contend
    for (int i = 0; i < POOL_SIZE; i += 2) begin
      id_pool[i]     = rand_id();
      id_pool[i + 1] = slot_partner(id_pool[i]);
    end

    for (int n = 0; n < RAND_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        kind = kind_t'(REQ_FIRST_UNKNOWN + $urandom_range(0, 3));
      else if (pick < 30)
        kind = hlts_pkg::REQ_READ;
      else if (pick < 65)
        kind = hlts_pkg::REQ_ACQUIRE;
      else if (pick < 80)
        kind = hlts_pkg::REQ_ABORT;
      else
        kind = hlts_pkg::REQ_COMMIT;
      if ($urandom_range(0, 99) < 20)
        id_pick = rand_id();
      else
        id_pick = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      add_req(kind, id_pick, (n == RAND_REQS / 2) || (n == RAND_REQS - 100));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // wait until every word is sent, then for the replies to drain
    do @(posedge clk); while (pending_reqs.size() != 0 || req_ch.valid);
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));

    $display("tb: %0d requests sent, %0d replies checked, %0d mismatches",
             n_accepted, n_replies, n_errors);
    $display("tb: %0d lock grants, %0d rejects, %0d reads, %0d passed on",
             n_grants, n_rejects, n_reads, n_passed);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #20ms;
    $display("tb: timeout with %0d replies outstanding", replies_due.size());
    $display("tb: failure");
    $finish;
  end

endmodule
